// ===== rtl/bmhq_pkg.sv =====
// Shared types and constants for the binary max-heap queue.
package bmhq_pkg;

	localparam int KeyW   = 16;
	localparam int TagW   = 16;
	localparam int CountW = 9;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_PEEK   = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		DP_NOP    = 3'd0,
		DP_LOAD   = 3'd1,
		DP_RD_UP  = 3'd2,
		DP_UP     = 3'd3,
		DP_RD_DN  = 3'd4,
		DP_DN     = 3'd5,
		DP_REMOVE = 3'd6,
		DP_RD_TOP = 3'd7
	} dp_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic up_done;
		logic dn_done;
	} dp_status_t;

endpackage

// ===== rtl/binary_max_heap_queue_core.sv =====
// Top level of the binary max-heap priority queue.
// A transaction starts when start is high and busy is low; its result appears for one
// cycle with done high and cannot be stalled. Clear, a failed operation and a peek do not
// walk the heap; insert and remove walk it one level at a time, with one read and one
// write of the heap memory each level.
module binary_max_heap_queue_core #(
	parameter int DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [15:0] entry_key,
	input  logic [15:0] entry_tag,
	output logic        done,
	output logic        ok,
	output logic [15:0] top_key,
	output logic [15:0] top_tag,
	output logic [8:0]  entry_count
);
	bmhq_pkg::dp_cmd_t    cmd;
	bmhq_pkg::dp_status_t status;
	logic clear, res_load, res_ok, res_top;

	bmhq_ctrl u_ctrl (
		.clk, .arst_n, .start, .kind, .status, .cmd, .clear,
		.res_load, .res_ok, .res_top, .busy, .done
	);

	bmhq_datapath #(.DEPTH(DEPTH)) u_dp (
		.clk, .arst_n, .cmd, .clear, .res_load, .res_ok, .res_top,
		.in_key(entry_key), .in_tag(entry_tag), .status,
		.ok, .top_key, .top_tag, .entry_count
	);
endmodule

// ===== rtl/bmhq_datapath.sv =====
// Heap storage, fill count, sift pointer and result registers.
module bmhq_datapath #(
	parameter int DEPTH = 256
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  bmhq_pkg::dp_cmd_t       cmd,
	input  logic                    clear,
	input  logic                    res_load,
	input  logic                    res_ok,
	input  logic                    res_top,
	input  logic [bmhq_pkg::KeyW-1:0] in_key,
	input  logic [bmhq_pkg::TagW-1:0] in_tag,
	output bmhq_pkg::dp_status_t    status,
	output logic                    ok,
	output logic [bmhq_pkg::KeyW-1:0] top_key,
	output logic [bmhq_pkg::TagW-1:0] top_tag,
	output logic [bmhq_pkg::CountW-1:0] entry_count
);
	localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = AW + 1;

	logic [bmhq_pkg::KeyW+bmhq_pkg::TagW-1:0] mem [DEPTH];

	logic [CW-1:0] cnt_q;
	logic [PW-1:0] pos_q;
	logic [bmhq_pkg::KeyW-1:0] cur_key_q, a_key_q, b_key_q;
	logic [bmhq_pkg::TagW-1:0] cur_tag_q, a_tag_q, b_tag_q;
	logic          done_q;
	logic          first_rd_q;
	logic [bmhq_pkg::KeyW-1:0] top_key_q;
	logic [bmhq_pkg::TagW-1:0] top_tag_q;
	logic          ok_q;

	// Read ports: port A (parent, left child or root), port B (right child or last entry).
	logic [PW-1:0] rd_a, rd_b, lc, rc, par, wr_addr;
	logic [bmhq_pkg::KeyW+bmhq_pkg::TagW-1:0] wr_data;
	logic          wr_en;
	logic          lhi, rhi, go_right;

	assign lc  = PW'(2) * pos_q + PW'(1);
	assign rc  = lc + PW'(1);
	assign par = (pos_q - PW'(1)) >> 1;

	always_comb begin
		rd_a = par;
		rd_b = rc;
		if (cmd == bmhq_pkg::DP_RD_DN) begin
			rd_a = lc;
		end else if (cmd == bmhq_pkg::DP_REMOVE || cmd == bmhq_pkg::DP_RD_TOP) begin
			rd_a = '0;
			rd_b = PW'(cnt_q - CW'(1));
		end
	end

	always_ff @(posedge clk) begin
		a_key_q <= mem[rd_a[AW-1:0]][bmhq_pkg::KeyW+bmhq_pkg::TagW-1:bmhq_pkg::TagW];
		a_tag_q <= mem[rd_a[AW-1:0]][bmhq_pkg::TagW-1:0];
		b_key_q <= mem[rd_b[AW-1:0]][bmhq_pkg::KeyW+bmhq_pkg::TagW-1:bmhq_pkg::TagW];
		b_tag_q <= mem[rd_b[AW-1:0]][bmhq_pkg::TagW-1:0];
		if (wr_en) begin
			mem[wr_addr[AW-1:0]] <= wr_data;
		end
	end

	assign lhi = ({1'b0, lc} < {1'b0, PW'(cnt_q)}) && (cur_key_q < a_key_q);
	assign rhi = ({1'b0, rc} < {1'b0, PW'(cnt_q)}) && (cur_key_q < b_key_q);
	assign go_right = rhi && !(lhi && (a_key_q > b_key_q));

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = {cur_key_q, cur_tag_q};
		case (cmd)
			bmhq_pkg::DP_LOAD: begin
				wr_en   = 1'b1;
				wr_addr = PW'(cnt_q);
				wr_data = {in_key, in_tag};
			end
			bmhq_pkg::DP_UP: begin
				wr_en = 1'b1;
				if (pos_q != '0 && cur_key_q > a_key_q) begin
					wr_data = {a_key_q, a_tag_q};
				end
			end
			bmhq_pkg::DP_DN: begin
				wr_en = 1'b1;
				if (go_right) begin
					wr_data = {b_key_q, b_tag_q};
				end else if (lhi) begin
					wr_data = {a_key_q, a_tag_q};
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			pos_q  <= '0;
			done_q <= 1'b0;
		end else begin
			if (clear) begin
				cnt_q <= '0;
			end
			case (cmd)
				bmhq_pkg::DP_LOAD: begin
					pos_q  <= PW'(cnt_q);
					cnt_q  <= cnt_q + CW'(1);
					done_q <= 1'b0;
				end
				bmhq_pkg::DP_UP: begin
					if (pos_q != '0 && cur_key_q > a_key_q) begin
						pos_q <= par;
					end else begin
						done_q <= 1'b1;
					end
				end
				bmhq_pkg::DP_REMOVE: begin
					pos_q  <= '0;
					cnt_q  <= cnt_q - CW'(1);
					done_q <= 1'b0;
				end
				bmhq_pkg::DP_DN: begin
					if (go_right) begin
						pos_q <= rc;
					end else if (lhi) begin
						pos_q <= lc;
					end else begin
						done_q <= 1'b1;
					end
				end
				default: begin
					done_q <= done_q;
				end
			endcase
		end
	end

	// The entry being sifted is held in registers and written to memory where it comes to rest.
	always_ff @(posedge clk) begin
		if (cmd == bmhq_pkg::DP_LOAD) begin
			cur_key_q <= in_key;
			cur_tag_q <= in_tag;
		end else if (cmd == bmhq_pkg::DP_RD_DN && first_rd_q) begin
			cur_key_q <= b_key_q;
			cur_tag_q <= b_tag_q;
		end
		if (cmd == bmhq_pkg::DP_RD_DN && first_rd_q) begin
			top_key_q <= a_key_q;
			top_tag_q <= a_tag_q;
		end else if (cmd == bmhq_pkg::DP_RD_UP && res_top) begin
			top_key_q <= a_key_q;
			top_tag_q <= a_tag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q <= 1'b0;
		end else if (res_load) begin
			ok_q <= res_ok;
		end
	end

	// first_rd_q marks the first read after a remove, where the root and last entry arrive.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_rd_q <= 1'b0;
		end else if (cmd == bmhq_pkg::DP_RD_DN) begin
			first_rd_q <= 1'b0;
		end else if (cmd == bmhq_pkg::DP_REMOVE) begin
			first_rd_q <= 1'b1;
		end
	end

	assign status.empty   = (cnt_q == '0);
	assign status.full    = (cnt_q == CW'(DEPTH));
	assign status.up_done = done_q;
	assign status.dn_done = done_q;

	assign ok          = ok_q;
	assign top_key     = (ok_q && res_top) ? top_key_q : '0;
	assign top_tag     = (ok_q && res_top) ? top_tag_q : '0;
	assign entry_count = bmhq_pkg::CountW'(cnt_q);
endmodule

// ===== rtl/bmhq_ctrl.sv =====
// Operation sequencer for the binary max-heap queue.
module bmhq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [1:0]           kind,
	input  bmhq_pkg::dp_status_t status,
	output bmhq_pkg::dp_cmd_t    cmd,
	output logic                 clear,
	output logic                 res_load,
	output logic                 res_ok,
	output logic                 res_top,
	output logic                 busy,
	output logic                 done
);
	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_UPRD  = 10'b0000000010,
		ST_UPWR  = 10'b0000000100,
		ST_RMRD  = 10'b0000001000,
		ST_RMLD  = 10'b0000010000,
		ST_DNRD  = 10'b0000100000,
		ST_DNWR  = 10'b0001000000,
		ST_PKRD  = 10'b0010000000,
		ST_PKWT  = 10'b0100000000,
		ST_DONE  = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	logic   top_q, top_d;
	logic   ok_d;

	always_comb begin
		state_d  = state_q;
		cmd      = bmhq_pkg::DP_NOP;
		clear    = 1'b0;
		res_load = 1'b0;
		ok_d     = 1'b1;
		top_d    = top_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					res_load = 1'b1;
					top_d    = 1'b0;
					case (kind)
						bmhq_pkg::KIND_INSERT: begin
							if (status.full) begin
								ok_d    = 1'b0;
								state_d = ST_DONE;
							end else begin
								cmd     = bmhq_pkg::DP_LOAD;
								state_d = ST_UPRD;
							end
						end
						bmhq_pkg::KIND_REMOVE: begin
							top_d = 1'b1;
							if (status.empty) begin
								ok_d    = 1'b0;
								state_d = ST_DONE;
							end else begin
								cmd     = bmhq_pkg::DP_REMOVE;
								state_d = ST_RMLD;
							end
						end
						bmhq_pkg::KIND_PEEK: begin
							top_d = 1'b1;
							if (status.empty) begin
								ok_d    = 1'b0;
								state_d = ST_DONE;
							end else begin
								cmd     = bmhq_pkg::DP_RD_TOP;
								state_d = ST_PKRD;
							end
						end
						default: begin
							clear   = 1'b1;
							state_d = ST_DONE;
						end
					endcase
				end
			end
			ST_UPRD: begin
				cmd     = bmhq_pkg::DP_RD_UP;
				state_d = ST_UPWR;
			end
			ST_UPWR: begin
				if (status.up_done) begin
					state_d = ST_DONE;
				end else begin
					cmd     = bmhq_pkg::DP_UP;
					state_d = ST_UPRD;
				end
			end
			ST_RMLD: begin
				cmd     = bmhq_pkg::DP_RD_DN;
				state_d = ST_DNRD;
			end
			ST_DNRD: begin
				cmd     = bmhq_pkg::DP_RD_DN;
				state_d = ST_DNWR;
			end
			ST_DNWR: begin
				if (status.dn_done) begin
					state_d = ST_DONE;
				end else begin
					cmd     = bmhq_pkg::DP_DN;
					state_d = ST_DNRD;
				end
			end
			ST_PKRD: begin
				cmd     = bmhq_pkg::DP_RD_UP;
				state_d = ST_PKWT;
			end
			ST_PKWT: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			top_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			top_q   <= top_d;
		end
	end

	assign res_ok  = ok_d;
	assign res_top = top_q;
	assign busy    = (state_q != ST_IDLE);
	assign done    = (state_q == ST_DONE);
endmodule

// ===== sim/heapq_checker.sv =====
// Checker that predicts heap queue results from observed commands and compares them.
module heapq_checker #(
	parameter int DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  kind,
	input  logic [15:0] entry_key,
	input  logic [15:0] entry_tag,
	input  logic        done,
	input  logic        ok,
	input  logic [15:0] top_key,
	input  logic [15:0] top_tag,
	input  logic [8:0]  entry_count,
	output int          fail_count,
	output int          pending,
	output int          result_total
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        ok;
		logic [15:0] key;
		logic [15:0] tag;
		logic [8:0]  count;
	} heap_result_t;

	logic [15:0] heap_keys [DEPTH];
	logic [15:0] heap_tags [DEPTH];
	int unsigned heap_fill;
	heap_result_t expected_results [$];

	initial begin
		fail_count = 0;
		result_total = 0;
		heap_fill = 0;
		pending = 0;
	end

	function automatic void swap_slots(int unsigned a, int unsigned b);
		logic [15:0] k;
		logic [15:0] t;
		k = heap_keys[a];
		t = heap_tags[a];
		heap_keys[a] = heap_keys[b];
		heap_tags[a] = heap_tags[b];
		heap_keys[b] = k;
		heap_tags[b] = t;
	endfunction

	function automatic heap_result_t apply_command(bmhq_pkg::kind_t op, logic [15:0] key,
			logic [15:0] tag);
		heap_result_t r;
		int unsigned pos;
		int unsigned lc;
		int unsigned rc;
		int unsigned nxt;
		bit lhi;
		bit rhi;
		r = '0;
		case (op)
			bmhq_pkg::KIND_INSERT: begin
				if (heap_fill < DEPTH) begin
					pos = heap_fill;
					heap_keys[pos] = key;
					heap_tags[pos] = tag;
					heap_fill++;
					while (pos > 0 && heap_keys[pos] > heap_keys[(pos - 1) / 2]) begin
						swap_slots(pos, (pos - 1) / 2);
						pos = (pos - 1) / 2;
					end
					r.ok = 1'b1;
				end
			end
			bmhq_pkg::KIND_REMOVE: begin
				if (heap_fill > 0) begin
					r.key = heap_keys[0];
					r.tag = heap_tags[0];
					heap_keys[0] = heap_keys[heap_fill - 1];
					heap_tags[0] = heap_tags[heap_fill - 1];
					heap_fill--;
					pos = 0;
					forever begin
						lc = 2 * pos + 1;
						rc = lc + 1;
						lhi = (lc < heap_fill) && (heap_keys[pos] < heap_keys[lc]);
						rhi = (rc < heap_fill) && (heap_keys[pos] < heap_keys[rc]);
						if (lhi && rhi) nxt = (heap_keys[lc] > heap_keys[rc]) ? lc : rc;
						else if (lhi) nxt = lc;
						else if (rhi) nxt = rc;
						else break;
						swap_slots(pos, nxt);
						pos = nxt;
					end
					r.ok = 1'b1;
				end
			end
			bmhq_pkg::KIND_PEEK: begin
				if (heap_fill > 0) begin
					r.key = heap_keys[0];
					r.tag = heap_tags[0];
					r.ok = 1'b1;
				end
			end
			default: begin
				heap_fill = 0;
				r.ok = 1'b1;
			end
		endcase
		r.count = heap_fill[8:0];
		return r;
	endfunction

	always @(posedge clk) begin
		heap_result_t exp_r;
		if (arst_n) begin
			if (done) begin
				result_total++;
				if (expected_results.size() == 0) begin
					$error("result with no command outstanding");
					fail_count++;
				end else begin
					exp_r = expected_results.pop_front();
					if (ok !== exp_r.ok) begin
						$error("ok: expected %0d, got %0d", exp_r.ok, ok);
						fail_count++;
					end
					if (top_key !== exp_r.key) begin
						$error("top_key: expected %0h, got %0h", exp_r.key, top_key);
						fail_count++;
					end
					if (top_tag !== exp_r.tag) begin
						$error("top_tag: expected %0h, got %0h", exp_r.tag, top_tag);
						fail_count++;
					end
					if (entry_count !== exp_r.count) begin
						$error("entry_count: expected %0d, got %0d", exp_r.count,
							entry_count);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				expected_results.push_back(apply_command(bmhq_pkg::kind_t'(kind),
					entry_key, entry_tag));
			pending = expected_results.size();
		end
	end
endmodule

// ===== sim/tb_binary_max_heap_queue_core.sv =====
// Testbench top that drives heap queue commands and reports the verdict.
module tb_binary_max_heap_queue_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 256;
	localparam int STALL_LIMIT = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  kind = bmhq_pkg::KIND_PEEK;
	logic [15:0] entry_key = '0;
	logic [15:0] entry_tag = '0;
	logic        done;
	logic        ok;
	logic [15:0] top_key;
	logic [15:0] top_tag;
	logic [8:0]  entry_count;
	int          fail_count;
	int          pending;
	int          result_total;
	int          idle_cycles = 0;
	int          sent_total = 0;
	bit          allow_gaps = 1'b1;

	always #10 clk = ~clk;

	binary_max_heap_queue_core #(.DEPTH(DEPTH)) u_dut (
		.clk, .arst_n, .start, .busy, .kind, .entry_key, .entry_tag,
		.done, .ok, .top_key, .top_tag, .entry_count
	);

	heapq_checker #(.DEPTH(DEPTH)) u_checker (
		.clk, .arst_n, .start, .busy, .kind, .entry_key, .entry_tag,
		.done, .ok, .top_key, .top_tag, .entry_count,
		.fail_count, .pending, .result_total
	);

	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_binary_max_heap_queue_core: errors");
			$finish;
		end
	end

	task automatic send_command(bmhq_pkg::kind_t op, logic [15:0] key, logic [15:0] tag);
		int gap;
		if (allow_gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 15);
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		kind <= op;
		entry_key <= key;
		entry_tag <= tag;
		do @(posedge clk); while (busy);
		sent_total++;
		@(negedge clk);
	endtask

	task automatic random_command(int insert_weight);
		int r;
		r = $urandom_range(0, 99);
		if (r < insert_weight)
			send_command(bmhq_pkg::KIND_INSERT, ($urandom_range(0, 1) ?
				16'($urandom_range(0, 7)) : 16'($urandom_range(0, 65535))),
				16'($urandom_range(0, 65535)));
		else if (r < 92) send_command(bmhq_pkg::KIND_REMOVE, 16'($urandom), 16'($urandom));
		else if (r < 98) send_command(bmhq_pkg::KIND_PEEK, 16'($urandom), 16'($urandom));
		else send_command(bmhq_pkg::KIND_CLEAR, 16'($urandom), 16'($urandom));
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_command(bmhq_pkg::KIND_REMOVE, 16'hFFFF, 16'hFFFF);
		send_command(bmhq_pkg::KIND_PEEK, 16'h0000, 16'h0000);
		send_command(bmhq_pkg::KIND_INSERT, 16'h0000, 16'hFFFF);
		send_command(bmhq_pkg::KIND_INSERT, 16'hFFFF, 16'h0000);
		send_command(bmhq_pkg::KIND_INSERT, 16'h1234, 16'h0001);
		send_command(bmhq_pkg::KIND_INSERT, 16'h1234, 16'h0002);
		send_command(bmhq_pkg::KIND_INSERT, 16'h1234, 16'h0003);
		send_command(bmhq_pkg::KIND_PEEK, 16'h0, 16'h0);
		repeat (5) send_command(bmhq_pkg::KIND_REMOVE, 16'h0, 16'h0);
		send_command(bmhq_pkg::KIND_REMOVE, 16'h0, 16'h0);
		send_command(bmhq_pkg::KIND_INSERT, 16'h0005, 16'hAAAA);
		send_command(bmhq_pkg::KIND_CLEAR, 16'hFFFF, 16'hFFFF);
		send_command(bmhq_pkg::KIND_PEEK, 16'h0, 16'h0);

		// Fill to capacity, overflow, then drain completely.
		for (int i = 0; i < DEPTH; i++)
			send_command(bmhq_pkg::KIND_INSERT, 16'($urandom_range(0, 31)),
				16'($urandom_range(0, 65535)));
		send_command(bmhq_pkg::KIND_INSERT, 16'hFFFF, 16'hFFFF);
		send_command(bmhq_pkg::KIND_PEEK, 16'h0, 16'h0);
		for (int i = 0; i < DEPTH; i++) send_command(bmhq_pkg::KIND_REMOVE, 16'h0, 16'h0);
		send_command(bmhq_pkg::KIND_REMOVE, 16'h0, 16'h0);

		for (int i = 0; i < 270; i++) begin
			if (i >= 220) allow_gaps = 1'b0;
			random_command((i / 100) % 2 ? 35 : 65);
		end
		start <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("Sent %0d commands and checked %0d results, including full and empty heaps.",
			sent_total, result_total);
		if (fail_count == 0 && pending == 0)
			$display("tb_binary_max_heap_queue_core: clean");
		else
			$display("tb_binary_max_heap_queue_core: errors");
		$finish;
	end
endmodule
